### design/bhq_pkg.sv
// Shared constants and types for the bitcrush hold quantizer.
`timescale 1ns / 1ps

package bhq_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int MAX_QUANT_BITS = 16;
   localparam int PHASE_BITS     = 24;
   localparam int STEP_BITS      = PHASE_BITS + 1;
   localparam int QBITS_W        = 5;
   localparam int CSR_DATA_W     = STEP_BITS;
   localparam int CSR_IDX_W      = 1;
   localparam int FIFO_DEPTH     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANT_BITS = 1'd1;

   localparam logic [STEP_BITS-1:0] STEP_RESET  = STEP_BITS'(1) << PHASE_BITS;
   localparam logic [QBITS_W-1:0]   QBITS_RESET = QBITS_W'(16);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [QBITS_W-1:0]            qbits_type;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } frame_type;

endpackage

### design/bitcrush_hold_quantizer.sv
// Top level of the bitcrush hold quantizer: control registers and block wiring.
`timescale 1ns / 1ps
// Path: a pushed frame passes through the queue, the multiply stage, the fraction
//   stage and the output register before it can be popped.
// Throughput: up to one frame per clock; the two-entry queue and the output
//   register let the front end and the quantizer stall independently.
// Reset (synchronous, active high): phase and holds clear to zero, phase_step
//   returns to one full step per frame, quant_bits to 16, all queues empty.

module bitcrush_hold_quantizer import bhq_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  sample_type            req_left_sample,
   input  sample_type            req_right_sample,
   input  logic                  req_stereo,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sample_type            rsp_left_out,
   output sample_type            rsp_right_out,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [STEP_BITS-1:0] phase_step_ff;
   qbits_type            quant_bits_ff;
   logic                 req_beat;
   frame_type            front_frame;
   frame_type            fifo_frame;
   logic                 fifo_full, fifo_empty, fifo_pop;

   // Control regs; software must write only while block is idle; unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= STEP_RESET;
         quant_bits_ff <= QBITS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata[STEP_BITS-1:0];
            CSR_QUANT_BITS: quant_bits_ff <= csr_wdata[QBITS_W-1:0];
            default: ;
         endcase
      end
   end

   // A request beat advances the phase and pushes the held frame.
   assign req_beat = req_push && !fifo_full;
   assign req_full = fifo_full;

   bhq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .phase_step   (phase_step_ff),
      .push         (req_beat),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .stereo       (req_stereo),
      .frame_out    (front_frame)
   );

   // Decouple the hold logic from the quantizer pipeline.
   bhq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_beat),
      .push_data (front_frame),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_frame),
      .empty     (fifo_empty)
   );

   // Quantize both channels and hold the result until popped.
   bhq_back u_back (
      .clock         (clock),
      .reset         (reset),
      .quant_bits    (quant_bits_ff),
      .fifo_empty    (fifo_empty),
      .fifo_data     (fifo_frame),
      .fifo_pop      (fifo_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule

### design/bhq_front.sv
// Front end: phase accumulator and sample-and-hold registers.
`timescale 1ns / 1ps

module bhq_front import bhq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [STEP_BITS-1:0] phase_step,
   input  logic                 push,
   input  sample_type           left_sample,
   input  sample_type           right_sample,
   input  logic                 stereo,
   output frame_type            frame_out
);

   localparam int SUM_W = STEP_BITS + 1;

   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   sample_type            hold_left_ff, hold_left_in;
   sample_type            hold_right_ff, hold_right_in;
   logic [SUM_W-1:0]      phase_sum;
   logic                  tick;

   always_comb begin
      phase_sum    = SUM_W'(phase_acc_ff) + SUM_W'(phase_step);
      tick         = phase_sum[SUM_W-1:PHASE_BITS] != '0;
      phase_acc_in = phase_sum[PHASE_BITS-1:0];
      // latch on wrap; a mono frame copies left into both holds
      hold_left_in  = tick ? left_sample : hold_left_ff;
      hold_right_in = tick ? (stereo ? right_sample : left_sample) : hold_right_ff;
   end

   assign frame_out.left  = hold_left_in;
   assign frame_out.right = hold_right_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff  <= '0;
         hold_left_ff  <= '0;
         hold_right_ff <= '0;
      end else if (push) begin
         phase_acc_ff  <= phase_acc_in;
         hold_left_ff  <= hold_left_in;
         hold_right_ff <= hold_right_in;
      end
   end

endmodule

### design/bhq_fifo.sv
// Short frame queue between the front end and the quantizer.
`timescale 1ns / 1ps

module bhq_fifo import bhq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   input  logic      pop,
   output frame_type pop_data,
   output logic      empty
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   frame_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_W'(FIFO_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/bhq_back.sv
// Back end: three-stage quantizer pipeline whose last stage is the output register.
`timescale 1ns / 1ps

module bhq_back import bhq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qbits_type quant_bits,
   input  logic      fifo_empty,
   input  frame_type fifo_data,
   output logic      fifo_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output sample_type rsp_left_out,
   output sample_type rsp_right_out
);

   localparam int LANES     = 2;
   localparam int PROD_W    = SAMPLE_BITS + MAX_QUANT_BITS;
   localparam int REP_STEPS = $clog2(SAMPLE_BITS);
   localparam int SHIFT_W   = $clog2(MAX_QUANT_BITS * (1 << (REP_STEPS - 1)) + 1);
   localparam logic [SAMPLE_BITS-1:0] MAX_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [PROD_W:0] HALF_LSB = (PROD_W+1)'(1) << (SAMPLE_BITS - 2);

   // Fraction n/L with L = 2^b - 1 is n's b-bit pattern repeated; build it by doubling.
   function automatic logic [PROD_W-1:0] repeat_fill(
      input logic [MAX_QUANT_BITS-1:0] n,
      input qbits_type                 b
   );
      logic [PROD_W-1:0]  r;
      logic [SHIFT_W-1:0] sh;
      r = {n, (PROD_W - MAX_QUANT_BITS)'(0)} << (qbits_type'(MAX_QUANT_BITS) - b);
      for (int k = 0; k < REP_STEPS; k++) begin
         sh = SHIFT_W'(b) << k;
         r  = r | (r >> sh);
      end
      return r;
   endfunction

   qbits_type                 bits_eff;
   logic [MAX_QUANT_BITS-1:0] levels;

   logic                   s1_vld_ff, s2_vld_ff, out_vld_ff;
   logic                   out_load, s2_load, s2_free, s1_free;
   logic [PROD_W-1:0]      s1_prod_ff [LANES];
   logic [PROD_W-1:0]      s1_prod_in [LANES];
   logic                   s1_neg_ff  [LANES];
   logic                   s1_neg_in  [LANES];
   logic [SAMPLE_BITS-1:0] s2_frac_ff [LANES];
   logic [SAMPLE_BITS-1:0] s2_frac_in [LANES];
   logic                   s2_neg_ff  [LANES];
   sample_type             out_ff     [LANES];
   sample_type             out_in     [LANES];
   sample_type             lane_raw   [LANES];

   always_comb begin
      if (quant_bits == '0) begin
         bits_eff = qbits_type'(1);
      end else if (quant_bits > qbits_type'(MAX_QUANT_BITS)) begin
         bits_eff = qbits_type'(MAX_QUANT_BITS);
      end else begin
         bits_eff = quant_bits;
      end
      levels = MAX_QUANT_BITS'((MAX_QUANT_BITS+1)'(1) << bits_eff) - MAX_QUANT_BITS'(1);
   end

   // handshake through the stages
   assign out_load = s2_vld_ff && (!out_vld_ff || rsp_pop);
   assign s2_free  = !s2_vld_ff || out_load;
   assign s2_load  = s1_vld_ff && s2_free;
   assign s1_free  = !s1_vld_ff || s2_load;
   assign fifo_pop = !fifo_empty && s1_free;

   assign lane_raw[0] = fifo_data.left;
   assign lane_raw[1] = fifo_data.right;

   always_comb begin
      logic [SAMPLE_BITS-1:0]    mag;
      logic [PROD_W:0]           rnd;
      logic [MAX_QUANT_BITS-1:0] n;
      logic [PROD_W-1:0]         rep;
      logic [SAMPLE_BITS:0]      qsum;
      logic [SAMPLE_BITS-1:0]    q;
      for (int i = 0; i < LANES; i++) begin
         // stage 1: magnitude times level count
         s1_neg_in[i]  = lane_raw[i][SAMPLE_BITS-1];
         mag           = s1_neg_in[i] ? SAMPLE_BITS'(-lane_raw[i]) : SAMPLE_BITS'(lane_raw[i]);
         s1_prod_in[i] = PROD_W'(mag) * PROD_W'(levels);
         // stage 2: round to level index, expand n/L as a binary fraction
         rnd           = (PROD_W+1)'(s1_prod_ff[i]) + HALF_LSB;
         n             = rnd[SAMPLE_BITS-1 +: MAX_QUANT_BITS];
         rep           = repeat_fill(n, bits_eff);
         s2_frac_in[i] = rep[PROD_W-1 -: SAMPLE_BITS];
         // stage 3: round to Q1.23, saturate, restore sign
         qsum = (SAMPLE_BITS+1)'(s2_frac_ff[i]) + (SAMPLE_BITS+1)'(1);
         q    = qsum[SAMPLE_BITS:1];
         if (s2_neg_ff[i]) begin
            out_in[i] = sample_type'(-q);
         end else if (q > MAX_POS) begin
            out_in[i] = sample_type'(MAX_POS);
         end else begin
            out_in[i] = sample_type'(q);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         if (fifo_pop) begin
            s1_prod_ff[i] <= s1_prod_in[i];
            s1_neg_ff[i]  <= s1_neg_in[i];
         end
         if (s2_load) begin
            s2_frac_ff[i] <= s2_frac_in[i];
            s2_neg_ff[i]  <= s1_neg_ff[i];
         end
         if (out_load) begin
            out_ff[i] <= out_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_vld_ff <= fifo_pop;
         end
         if (s2_free) begin
            s2_vld_ff <= s2_load;
         end
         if (!out_vld_ff || rsp_pop) begin
            out_vld_ff <= out_load;
         end
      end
   end

   assign rsp_empty     = !out_vld_ff;
   assign rsp_left_out  = out_ff[0];
   assign rsp_right_out = out_ff[1];

endmodule
